### rtl/agc_pkg.sv
// shared constants and request structs for the anagram group classifier
package agc_pkg;

  localparam int ALPHA_N    = 26;
  localparam int MAX_GROUPS = 256;
  localparam int CNT_W      = 8;

  localparam int IDX_W     = (ALPHA_N > 1) ? $clog2(ALPHA_N) : 1;
  localparam int GRP_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int USED_W    = $clog2(MAX_GROUPS + 1);
  localparam int SIG_DEPTH = MAX_GROUPS * ALPHA_N;
  localparam int ADDR_W    = (SIG_DEPTH > 1) ? $clog2(SIG_DEPTH) : 1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [IDX_W-1:0] K_LAST  = IDX_W'(ALPHA_N - 1);

  // request to the letter count bank
  typedef struct packed {
    logic             inc;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } cnt_ctl_t;

  // request to the signature ram
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  wdata;
  } mem_req_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_ALLOC  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

endpackage

### rtl/agc_counts.sv
// saturating letter count bank of the current word
module agc_counts
  import agc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cnt_ctl_t         ctl,
  output logic [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0] cnt_r [ALPHA_N];

  // one read address, shared by increment and compare
  assign rd_data = cnt_r[ctl.idx];

  // increment with saturation, clear after each word
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      for (int i = 0; i < ALPHA_N; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (ctl.inc && (rd_data != CNT_MAX)) begin
      cnt_r[ctl.idx] <= rd_data + CNT_W'(1);
    end
  end

endmodule

### rtl/agc_sig_mem.sv
// single-port signature ram, one count per entry, registered read
module agc_sig_mem
  import agc_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0] mem [SIG_DEPTH];
  logic [CNT_W-1:0] rd_r;

  // write and read at the one address
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rd_r <= mem[req.addr];
  end

  assign rd_data = rd_r;

endmodule

### rtl/agc_seq.sv
// sequencer: letter intake, signature search, allocation and result register
module agc_seq
  import agc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  input  logic [0:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic [1:0]       out_tuser,
  input  logic [CNT_W-1:0] cnt_rd,
  input  logic [CNT_W-1:0] mem_rd,
  output cnt_ctl_t         cnt_ctl,
  output mem_req_t         mem_req
);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [GRP_W-1:0]  g_r, g_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              issue_r, issue_nxt;
  logic              p_v_r, p_v_nxt;
  logic [IDX_W-1:0]  p_k_r, p_k_nxt;
  logic [GRP_W-1:0]  p_g_r, p_g_nxt;
  logic              p_last_r, p_last_nxt;
  logic              p_lastg_r, p_lastg_nxt;
  logic              ok_r, ok_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [7:0]        res_id_r, res_id_nxt;
  logic              res_new_r, res_new_nxt;
  logic              res_full_r, res_full_nxt;
  logic              out_v_r, out_v_nxt;
  logic [7:0]        out_id_r, out_id_nxt;
  logic [1:0]        out_flags_r, out_flags_nxt;

  logic fin;
  logic ltr_ok;
  logic eq;
  logic last_grp;

  assign fin      = in_tlast | in_tuser[0];
  assign ltr_ok   = !in_tuser[0] && (7'(in_tdata[4:0]) < 7'(ALPHA_N));
  assign eq       = (mem_rd == cnt_rd);
  assign last_grp = ((USED_W'(g_r) + USED_W'(1)) == used_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_flags_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    g_nxt         = g_r;
    base_nxt      = base_r;
    issue_nxt     = issue_r;
    p_v_nxt       = 1'b0;
    p_k_nxt       = p_k_r;
    p_g_nxt       = p_g_r;
    p_last_nxt    = p_last_r;
    p_lastg_nxt   = p_lastg_r;
    ok_nxt        = ok_r;
    used_nxt      = used_r;
    res_id_nxt    = res_id_r;
    res_new_nxt   = res_new_r;
    res_full_nxt  = res_full_r;
    out_id_nxt    = out_id_r;
    out_flags_nxt = out_flags_r;
    out_v_nxt     = out_v_r && !out_tready;
    cnt_ctl       = '{inc: 1'b0, clr: 1'b0, idx: p_k_r};
    mem_req       = '{we: 1'b0, addr: base_r + ADDR_W'(k_r), wdata: cnt_rd};

    unique case (state_r)
      // count letters; at word end start the search, or the allocation when no group is stored
      S_IDLE: begin
        cnt_ctl.idx = IDX_W'(in_tdata[4:0]);
        if (in_tvalid) begin
          cnt_ctl.inc = ltr_ok;
          if (fin) begin
            k_nxt     = '0;
            g_nxt     = '0;
            base_nxt  = '0;
            ok_nxt    = 1'b1;
            issue_nxt = (used_r != '0);
            state_nxt = (used_r != '0) ? S_SEARCH : S_ALLOC;
          end
        end
      end

      // read one stored count per cycle, compare it in the next cycle
      S_SEARCH: begin
        if (issue_r) begin
          p_v_nxt     = 1'b1;
          p_k_nxt     = k_r;
          p_g_nxt     = g_r;
          p_last_nxt  = (k_r == K_LAST);
          p_lastg_nxt = (k_r == K_LAST) && last_grp;
          if (k_r == K_LAST) begin
            k_nxt    = '0;
            g_nxt    = g_r + GRP_W'(1);
            base_nxt = base_r + ADDR_W'(ALPHA_N);
            if (last_grp) begin
              issue_nxt = 1'b0;
            end
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
        if (p_v_r) begin
          if (p_last_r) begin
            ok_nxt = 1'b1;
            if (eq && ok_r) begin
              res_id_nxt   = 8'(p_g_r);
              res_new_nxt  = 1'b0;
              res_full_nxt = 1'b0;
              state_nxt    = S_RESULT;
            end else if (p_lastg_r) begin
              if (used_r == USED_W'(MAX_GROUPS)) begin
                res_id_nxt   = '0;
                res_new_nxt  = 1'b0;
                res_full_nxt = 1'b1;
                state_nxt    = S_RESULT;
              end else begin
                k_nxt     = '0;
                state_nxt = S_ALLOC;
              end
            end
          end else begin
            ok_nxt = eq && ok_r;
          end
        end
      end

      // copy the counts into the next free group entry
      S_ALLOC: begin
        cnt_ctl.idx = k_r;
        mem_req.we  = 1'b1;
        if (k_r == K_LAST) begin
          res_id_nxt   = 8'(used_r);
          res_new_nxt  = 1'b1;
          res_full_nxt = 1'b0;
          used_nxt     = used_r + USED_W'(1);
          state_nxt    = S_RESULT;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end

      // hand the result to the output register, clear the counts
      S_RESULT: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt     = 1'b1;
          out_id_nxt    = res_id_r;
          out_flags_nxt = {res_full_r, res_new_r};
          cnt_ctl.clr   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      out_v_r <= 1'b0;
      issue_r <= 1'b0;
      p_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      out_v_r <= out_v_nxt;
      issue_r <= issue_nxt;
      p_v_r   <= p_v_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    g_r         <= g_nxt;
    base_r      <= base_nxt;
    p_k_r       <= p_k_nxt;
    p_g_r       <= p_g_nxt;
    p_last_r    <= p_last_nxt;
    p_lastg_r   <= p_lastg_nxt;
    ok_r        <= ok_nxt;
    res_id_r    <= res_id_nxt;
    res_new_r   <= res_new_nxt;
    res_full_r  <= res_full_nxt;
    out_id_r    <= out_id_nxt;
    out_flags_r <= out_flags_nxt;
  end

endmodule

### rtl/anagram_group_classifier.sv
// top level of the anagram group classifier
//
//   channel | direction | tdata           | tlast    | tuser
//   in_     | slave     | [4:0] letter    | word_end | [0] empty_word
//   out_    | master    | [7:0] group_id  | -        | [0] new_group, [1] table_full
//
// a letter that does not end a word leaves intake open
// a finished word is searched over the stored groups, one signature entry per
//   cycle via the single ram port; a miss with room left stores a new group
// in_tready is low from a word end until its result moves into the output register
// the output register holds a result while out_tready is low; intake resumes meanwhile
// synchronous reset clears the counts, the group count and the output valid
module anagram_group_classifier
  import agc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [4:0] letter
  input  logic       in_tlast,
  input  logic [0:0] in_tuser,   // [0] empty_word
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] group_id
  output logic [1:0] out_tuser   // [0] new_group, [1] table_full
);

  cnt_ctl_t         cnt_ctl;
  mem_req_t         mem_req;
  logic [CNT_W-1:0] cnt_rd;
  logic [CNT_W-1:0] mem_rd;

  // letter count bank
  agc_counts u_counts (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cnt_ctl),
    .rd_data (cnt_rd)
  );

  // stored group signatures
  agc_sig_mem u_sig_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  // sequencer and compare unit
  agc_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cnt_rd     (cnt_rd),
    .mem_rd     (mem_rd),
    .cnt_ctl    (cnt_ctl),
    .mem_req    (mem_req)
  );

endmodule

### rtl/agc_checker.sv
// port checker for the anagram group classifier, bound to the top level
module agc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic [0:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a full table gives id zero and no new group
  a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> (out_tdata == 8'd0) && !out_tuser[0])
    else $error("table full result with id or new group");

  // a finished word blocks intake while it is classified
  a_word_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tlast || in_tuser[0]) |=> !in_tready)
    else $error("intake open right after a word end");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind anagram_group_classifier agc_checker u_agc_checker (.*);

### dv/agc_word_checker.sv
`timescale 1ns / 100ps
// checker that predicts the anagram group of each finished word and compares the output stream
module agc_word_checker
  import agc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [4:0] letter
  input  logic       in_tlast,   // word_end
  input  logic [0:0] in_tuser,   // [0] empty_word
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] group_id
  input  logic [1:0] out_tuser,  // [0] new_group, [1] table_full
  output int         mismatches,
  output int         pending_words,
  output int         group_count
);

  typedef logic [ALPHA_N-1:0][CNT_W-1:0] signature_t;

  typedef struct packed {
    logic [7:0] group_id;
    logic       new_group;
    logic       table_full;
  } word_class_t;

  signature_t  tally;
  signature_t  sig_bank [MAX_GROUPS];
  int          groups_held = 0;
  int          errs = 0;
  word_class_t class_q [$];

  // count one letter and classify the word when it closes
  task automatic tally_letter(input logic [4:0] code, input logic close,
                              input logic empty_flag);
    word_class_t res;
    bit          hit;
    if (!empty_flag && code < ALPHA_N) begin
      if (tally[code] != CNT_MAX) tally[code] = tally[code] + 1'b1;
    end
    if (close || empty_flag) begin
      res = '0;
      hit = 1'b0;
      // first stored group with the same signature wins
      for (int g = 0; g < groups_held; g++) begin
        if (!hit && sig_bank[g] == tally) begin
          hit = 1'b1;
          res.group_id = 8'(g);
        end
      end
      // no match: allocate the next id, or refuse when the table is full
      if (!hit) begin
        if (groups_held < MAX_GROUPS) begin
          sig_bank[groups_held] = tally;
          res.group_id  = 8'(groups_held);
          res.new_group = 1'b1;
          groups_held++;
        end else begin
          res.table_full = 1'b1;
        end
      end
      tally = '0;
      class_q = {class_q, res};
    end
  endtask

  // watch both channels; results are checked before the same-edge request is predicted
  always @(posedge clk) begin
    word_class_t want;
    if (!rst_n) begin
      tally       = '0;
      groups_held = 0;
      class_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (class_q.size() == 0) begin
          errs++;
          $error("result with no word pending: group_id %0d new_group %0b table_full %0b",
                 out_tdata, out_tuser[0], out_tuser[1]);
        end else begin
          want = class_q.pop_front();
          if (out_tdata != want.group_id) begin
            errs++;
            $error("group_id: expected %0d, got %0d", want.group_id, out_tdata);
          end
          if (out_tuser[0] != want.new_group) begin
            errs++;
            $error("new_group: expected %0b, got %0b", want.new_group, out_tuser[0]);
          end
          if (out_tuser[1] != want.table_full) begin
            errs++;
            $error("table_full: expected %0b, got %0b", want.table_full, out_tuser[1]);
          end
        end
      end
      if (in_tvalid && in_tready) tally_letter(in_tdata[4:0], in_tlast, in_tuser[0]);
    end
    mismatches    <= errs;
    pending_words <= class_q.size();
    group_count   <= groups_held;
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// top of the anagram group classifier testbench: stimulus, receiver stalls and verdict
module tb;
  import agc_pkg::*;

  localparam int WORD_ITEMS  = 800;
  localparam int POOL_N      = 8;
  localparam int POOL_LEN    = 6;
  localparam int CYCLE_LIMIT = 60_000_000;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_BLOCKY
  } rx_mode_t;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;    // [4:0] letter
  logic       in_tlast   = 1'b0;  // word_end
  logic [0:0] in_tuser   = '0;    // [0] empty_word
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] group_id
  logic [1:0] out_tuser;          // [0] new_group, [1] table_full

  int mismatches;
  int pending_words;
  int group_count;

  int         items_sent = 0;
  int         burst_left = 0;
  int         cycle_count = 0;
  rx_mode_t   rx_mode = RX_STEADY;
  int         rx_left = 0;
  logic [4:0] pool_letters [POOL_N][POOL_LEN];
  int         pool_len [POOL_N];

  anagram_group_classifier u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  agc_word_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .mismatches    (mismatches),
    .pending_words (pending_words),
    .group_count   (group_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stall pattern: steady, coin flip, sparse and blocky phases
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STEADY: out_tready <= 1'b1;
      RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
      default:   out_tready <= ((rx_left % 50) < 10);
    endcase
  end

  // hold the input channel idle for some cycles
  task automatic hold_off(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // present one request and wait until it is taken; bursts end in a random gap
  task automatic push_letter(input int code, input bit close, input bit empty_flag);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, code[4:0]};
    in_tlast  <= close;
    in_tuser  <= empty_flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      hold_off($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 8);
    end
  endtask

  // stop sending until every finished word has its result
  task automatic drain_words();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // the same letter n times, closed on the last one
  task automatic push_run(input int code, input int n);
    for (int k = 0; k < n; k++) push_letter(code, k == n - 1, 1'b0);
  endtask

  // a pool word in shuffled order, sometimes closed by the empty flag instead
  task automatic push_anagram(input int b);
    logic [4:0] order [POOL_LEN];
    logic [4:0] swap;
    int         pick;
    bit         flag_close;
    flag_close = ($urandom_range(0, 7) == 0);
    for (int k = 0; k < pool_len[b]; k++) order[k] = pool_letters[b][k];
    for (int k = pool_len[b] - 1; k > 0; k--) begin
      pick        = $urandom_range(0, k);
      swap        = order[k];
      order[k]    = order[pick];
      order[pick] = swap;
    end
    for (int k = 0; k < pool_len[b]; k++)
      push_letter(order[k], !flag_close && k == pool_len[b] - 1, 1'b0);
    if (flag_close) push_letter($urandom_range(0, 31), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // random letters over the full code range, including out-of-range codes
  task automatic push_noise();
    int n;
    bit flag_close;
    n          = $urandom_range(0, POOL_LEN);
    flag_close = (n == 0) || ($urandom_range(0, 3) == 0);
    for (int k = 0; k < n; k++)
      push_letter($urandom_range(0, 31), !flag_close && k == n - 1, 1'b0);
    if (flag_close) push_letter($urandom_range(0, 31), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    bit paused;
    int roll;
    paused = 1'b0;

    // base words for the anagram traffic
    for (int b = 0; b < POOL_N; b++) begin
      pool_len[b] = $urandom_range(1, POOL_LEN);
      for (int k = 0; k < POOL_LEN; k++) pool_letters[b][k] = 5'($urandom_range(0, 25));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty word opens the all-zero group
    push_letter(31, 1'b0, 1'b1);
    // first and last letter, closed by an out-of-range code
    push_letter(0, 1'b0, 1'b0);
    push_letter(25, 1'b0, 1'b0);
    push_letter(31, 1'b1, 1'b0);
    // same letters in the other order match
    push_letter(25, 1'b0, 1'b0);
    push_letter(0, 1'b1, 1'b0);
    // empty flag with word end closes pending letters, its own letter dropped
    push_letter(3, 1'b0, 1'b0);
    push_letter(4, 1'b0, 1'b0);
    push_letter(5, 1'b1, 1'b1);
    // lone out-of-range letter leaves the empty signature
    push_letter(30, 1'b1, 1'b0);
    push_letter(4, 1'b0, 1'b0);
    push_letter(3, 1'b1, 1'b0);
    // empty flag alone closes pending letters
    push_letter(1, 1'b0, 1'b0);
    push_letter(2, 1'b0, 1'b0);
    push_letter(0, 1'b0, 1'b1);
    // one-hot letter codes
    push_letter(1, 1'b0, 1'b0);
    push_letter(2, 1'b0, 1'b0);
    push_letter(4, 1'b0, 1'b0);
    push_letter(8, 1'b0, 1'b0);
    push_letter(16, 1'b1, 1'b0);

    // saturating count
    push_run($urandom_range(0, 25), $urandom_range(256, 300));

    // random traffic, mostly anagrams of a small pool to keep the table short
    while (items_sent < WORD_ITEMS) begin
      if (!paused && items_sent >= WORD_ITEMS / 2) begin
        drain_words();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 399);
      if (roll == 0) push_run($urandom_range(0, 25), $urandom_range(250, 300));
      else if (roll < 60) push_noise();
      else push_anagram($urandom_range(0, POOL_N - 1));
    end
    drain_words();

    // fill the group table with two-letter words
    for (int i = 0; i < ALPHA_N; i++) begin
      for (int j = i; j < ALPHA_N; j++) begin
        if (group_count < MAX_GROUPS) begin
          push_letter(i, 1'b0, 1'b0);
          push_letter(j, 1'b1, 1'b0);
          drain_words();
        end
      end
    end

    // full table: a stored pair still matches, fresh signatures are refused
    push_letter(1, 1'b0, 1'b0);
    push_letter(0, 1'b1, 1'b0);
    push_run(25, 10);
    push_run(24, 300);
    push_letter(7, 1'b0, 1'b1);
    drain_words();
    repeat (64) @(posedge clk);

    if (mismatches == 0 && pending_words == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
